// File: hdl/signed_word_to_decimal_text_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the decimal text unit.
// ----------------------------------------------------------------------------
`ifndef SIGNED_WORD_TO_DECIMAL_TEXT_UNIT_DEFINES_SVH
`define SIGNED_WORD_TO_DECIMAL_TEXT_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SWDT_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
// next-cycle implication
`define SWDT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define SWDT_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define SWDT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: hdl/swdt_pkg.sv
// ----------------------------------------------------------------------------
// swdt_pkg
// Types and constants of the signed word to decimal text unit.
// ----------------------------------------------------------------------------
package swdt_pkg;

   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam int unsigned NIBBLE_BITS = 4;

   // shift-and-add-3 correction: digits of 5 or more get 3 added before the shift
   localparam logic [3:0] DABBLE_LIMIT  = 4'd5;
   localparam logic [3:0] DABBLE_ADJUST = 4'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_TRIM,
      ST_SIGN,
      ST_DIGIT
   } swdt_state_type;

endpackage

// File: hdl/swdt_dabble.sv
// ----------------------------------------------------------------------------
// swdt_dabble
// One double-dabble step: correct every BCD digit, then shift in one bit.
// ----------------------------------------------------------------------------
module swdt_dabble #(
   parameter int unsigned DIGITS = 10
) (
   input  logic [4*DIGITS-1:0] bcd_in,
   input  logic                shift_bit,
   output logic [4*DIGITS-1:0] bcd_out
);

   logic [4*DIGITS-1:0] corrected;

   always_comb begin
      for (int d = 0; d < DIGITS; d++) begin
         if (bcd_in[4*d +: 4] >= swdt_pkg::DABBLE_LIMIT) begin
            corrected[4*d +: 4] = bcd_in[4*d +: 4] + swdt_pkg::DABBLE_ADJUST;
         end else begin
            corrected[4*d +: 4] = bcd_in[4*d +: 4];
         end
      end
   end

   assign bcd_out = {corrected[4*DIGITS-2:0], shift_bit};

endmodule

// File: hdl/signed_word_to_decimal_text_unit.sv
// ----------------------------------------------------------------------------
// signed_word_to_decimal_text_unit
// Converts one two's complement word into its decimal ASCII text.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one WORD_BITS-bit two's complement word per transfer.
//   rsp channel: one ASCII character per transfer, most significant first,
//   a leading '-' for negative values, no leading zeros, rsp_last on the
//   final character. Zero gives the single character '0'.
//   After a transfer on req the unit is busy: the shared shift-and-add-3
//   step runs once per bit of the word, then leading zeros are stripped from
//   the DIGITS-digit result (DIGITS = digits of 2^(WORD_BITS-1)) and the
//   sign is decided, then the characters go one per cycle into the output
//   register, paused while rsp_stall holds a full output register.
//   req_stall is high while a word is being worked on; the next word is
//   taken once the last character sits in the output register.
//   rsp_stall holds the output register and pauses the character sequencer.
//   Reset empties the output register and returns the sequencer to idle.
// ----------------------------------------------------------------------------
`include "signed_word_to_decimal_text_unit_defines.svh"

module signed_word_to_decimal_text_unit #(
   parameter int unsigned WORD_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [WORD_BITS-1:0] req_word,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_character,
   output logic                 rsp_last
);

   // digits of the largest magnitude 2^(WORD_BITS-1): floor(k*log10(2)) + 1
   localparam int unsigned DIGITS      = ((WORD_BITS - 1) * 30103) / 100000 + 1;
   localparam int unsigned BCD_BITS    = swdt_pkg::NIBBLE_BITS * DIGITS;
   localparam int unsigned STEP_BITS   = $clog2(WORD_BITS);
   localparam int unsigned REMAIN_BITS = $clog2(DIGITS + 1);

   swdt_pkg::swdt_state_type state_ff, state_in;

   logic [WORD_BITS-1:0]   mag_ff, mag_in;
   logic [BCD_BITS-1:0]    bcd_ff, bcd_in;
   logic                   neg_ff, neg_in;
   logic [STEP_BITS-1:0]   step_ff, step_in;
   logic [REMAIN_BITS-1:0] remain_ff, remain_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             rsp_character_ff, rsp_character_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic [BCD_BITS-1:0]    bcd_step;
   logic [3:0]             top_digit;
   logic [BCD_BITS-1:0]    bcd_shifted;
   logic                   out_free;
   logic                   req_xfer;

   swdt_dabble #(
      .DIGITS (DIGITS)
   ) u_dabble (
      .bcd_in    (bcd_ff),
      .shift_bit (mag_ff[WORD_BITS-1]),
      .bcd_out   (bcd_step)
   );

   assign top_digit   = bcd_ff[BCD_BITS-1 -: 4];
   assign bcd_shifted = {bcd_ff[BCD_BITS-5:0], 4'd0};
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign req_stall   = (state_ff != swdt_pkg::ST_IDLE);
   assign req_xfer    = req_valid && !req_stall;

   always_comb begin
      state_in         = state_ff;
      mag_in           = mag_ff;
      bcd_in           = bcd_ff;
      neg_in           = neg_ff;
      step_in          = step_ff;
      remain_in        = remain_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_character_in = rsp_character_ff;
      rsp_last_in      = rsp_last_ff;

      unique case (state_ff)
         swdt_pkg::ST_IDLE: begin
            if (req_valid) begin
               neg_in   = req_word[WORD_BITS-1];
               mag_in   = req_word[WORD_BITS-1]
                        ? WORD_BITS'(~req_word + WORD_BITS'(1)) : req_word;
               bcd_in   = '0;
               step_in  = STEP_BITS'(WORD_BITS - 1);
               state_in = swdt_pkg::ST_CONVERT;
            end
         end
         swdt_pkg::ST_CONVERT: begin
            bcd_in  = bcd_step;
            mag_in  = {mag_ff[WORD_BITS-2:0], 1'b0};
            step_in = step_ff - STEP_BITS'(1);
            if (step_ff == '0) begin
               remain_in = REMAIN_BITS'(DIGITS);
               state_in  = swdt_pkg::ST_TRIM;
            end
         end
         swdt_pkg::ST_TRIM: begin
            // strip leading zeros, always keep at least one digit
            if (top_digit == 4'd0 && remain_ff != REMAIN_BITS'(1)) begin
               bcd_in    = bcd_shifted;
               remain_in = remain_ff - REMAIN_BITS'(1);
            end else if (neg_ff) begin
               state_in = swdt_pkg::ST_SIGN;
            end else begin
               state_in = swdt_pkg::ST_DIGIT;
            end
         end
         swdt_pkg::ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_character_in = swdt_pkg::CHAR_MINUS;
               rsp_last_in      = 1'b0;
               state_in         = swdt_pkg::ST_DIGIT;
            end
         end
         swdt_pkg::ST_DIGIT: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_character_in = swdt_pkg::CHAR_ZERO + {4'd0, top_digit};
               rsp_last_in      = (remain_ff == REMAIN_BITS'(1));
               bcd_in           = bcd_shifted;
               remain_in        = remain_ff - REMAIN_BITS'(1);
               if (remain_ff == REMAIN_BITS'(1)) begin
                  state_in = swdt_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = swdt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= swdt_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff           <= mag_in;
      bcd_ff           <= bcd_in;
      neg_ff           <= neg_in;
      step_ff          <= step_in;
      remain_ff        <= remain_in;
      rsp_character_ff <= rsp_character_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_last      = rsp_last_ff;

   `SWDT_ASSERT_NEXT(a_accept_starts_convert, clock, reset, req_xfer,
      state_ff == swdt_pkg::ST_CONVERT)
   `SWDT_ASSERT_IMPLIES(a_digit_count_live, clock, reset,
      state_ff == swdt_pkg::ST_DIGIT, remain_ff != '0)
   `SWDT_ASSERT_IMPLIES(a_minus_never_last, clock, reset,
      rsp_valid_ff && rsp_character_ff == swdt_pkg::CHAR_MINUS, !rsp_last_ff)
   `SWDT_ASSERT_IMPLIES(a_digit_in_range, clock, reset,
      rsp_valid_ff && rsp_character_ff != swdt_pkg::CHAR_MINUS,
      rsp_character_ff >= swdt_pkg::CHAR_ZERO && rsp_character_ff <= swdt_pkg::CHAR_NINE)

endmodule
